/* design/fcrm_pkg.sv */
// Shared types, widths and constants of the frequency ratio monitor.
`timescale 1ns / 1ps

package fcrm_pkg;

    localparam int FREQ_W    = 16;
    localparam int CNT_W     = 16;
    localparam int RATIO_W   = 23;
    localparam int SCALE_W   = 7;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int STEP_W    = $clog2(RATIO_W);

    localparam logic [SCALE_W-1:0] RATIO_SCALE = SCALE_W'(100);
    localparam logic [CNT_W-1:0]   MAX_COUNT   = {CNT_W{1'b1}};

    localparam logic [FREQ_W-1:0] THRESH_RESET  = FREQ_W'(20);
    localparam logic [FREQ_W-1:0] RATIO_RESET   = FREQ_W'(130);
    localparam logic [FREQ_W-1:0] PERSIST_RESET = FREQ_W'(400);

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_THRESH  = 2'd0,
        REG_RATIO   = 2'd1,
        REG_PERSIST = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ACK_WAIT_RISE = 2'd0,
        ACK_WAIT_FALL = 2'd1,
        ACK_HOLDOFF   = 2'd2
    } ack_phase_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_PREP   = 4'b0010,
        S_DIV    = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    typedef struct packed {
        logic [FREQ_W-1:0] compare_threshold;
        logic [FREQ_W-1:0] ratio_limit;
        logic [FREQ_W-1:0] persist_limit;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic div_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic active;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

/* design/dual_channel_frequency_ratio_monitor_top.sv */
// Top level of the dual channel frequency ratio monitor.
`timescale 1ns / 1ps

//  channel   direction  handshake             payload
//  input     in         in_valid / in_stall   local_freq .. ack_request (one tick)
//  output    out        out_valid / out_stall freq_error, mismatch_count,
//                                             ratio_percent, compare_active
//  config    in         APB psel / penable    paddr, pwdata, prdata
//
//  An item with an active comparison goes from accept to the next accept
//  through capture, prepare, the bit-serial divider (one quotient bit per
//  cycle) and commit. A skipped comparison goes from prepare straight to
//  commit. The result is visible in the cycle after the commit.
//  rst_n clears the counter, the error latch, the acknowledge phase, the
//  sequencer and the limits (20, 130, 400). A held result in the output
//  register does not block the next accept; only the commit waits on it.

module dual_channel_frequency_ratio_monitor_top
    import fcrm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    // input items
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [FREQ_W-1:0]  local_freq,
    input  logic [FREQ_W-1:0]  remote_freq,
    input  logic               muting,
    input  logic               local_standstill,
    input  logic               remote_standstill,
    input  logic               params_complete,
    input  logic               ack_request,

    // result items
    output logic               out_valid,
    input  logic               out_stall,
    output logic               freq_error,
    output logic [CNT_W-1:0]   mismatch_count,
    output logic [RATIO_W-1:0] ratio_percent,
    output logic               compare_active,

    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    // limit registers
    fcrm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: one item at a time through prepare, divide (active comparisons only), commit
    fcrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // divider, persistence counter, error latch, acknowledge phase, output register
    fcrm_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .local_freq        (local_freq),
        .remote_freq       (remote_freq),
        .muting            (muting),
        .local_standstill  (local_standstill),
        .remote_standstill (remote_standstill),
        .params_complete   (params_complete),
        .ack_request       (ack_request),
        .cfg               (cfg),
        .cmd               (cmd),
        .sts               (sts),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .freq_error        (freq_error),
        .mismatch_count    (mismatch_count),
        .ratio_percent     (ratio_percent),
        .compare_active    (compare_active)
    );

endmodule

/* design/fcrm_cfg.sv */
// APB register file holding the three monitor limits.
`timescale 1ns / 1ps

module fcrm_cfg
    import fcrm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                REG_THRESH:  cfg_next.compare_threshold = pwdata[FREQ_W-1:0];
                REG_RATIO:   cfg_next.ratio_limit       = pwdata[FREQ_W-1:0];
                REG_PERSIST: cfg_next.persist_limit     = pwdata[FREQ_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_THRESH:  prdata = DATA_W'(cfg_reg.compare_threshold);
            REG_RATIO:   prdata = DATA_W'(cfg_reg.ratio_limit);
            REG_PERSIST: prdata = DATA_W'(cfg_reg.persist_limit);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.compare_threshold <= THRESH_RESET;
            cfg_reg.ratio_limit       <= RATIO_RESET;
            cfg_reg.persist_limit     <= PERSIST_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/fcrm_ctrl.sv */
// Sequencer: accept, prepare, divide, commit.
`timescale 1ns / 1ps

module fcrm_ctrl
    import fcrm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = sts.active ? S_DIV : S_COMMIT;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                // hold until the output register has room
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/fcrm_dp.sv */
// Datapath: input capture, bit-serial ratio divider, counter, latch, output register.
`timescale 1ns / 1ps

module fcrm_dp
    import fcrm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [FREQ_W-1:0]  local_freq,
    input  logic [FREQ_W-1:0]  remote_freq,
    input  logic               muting,
    input  logic               local_standstill,
    input  logic               remote_standstill,
    input  logic               params_complete,
    input  logic               ack_request,
    input  cfg_t               cfg,
    input  cmd_t               cmd,
    output sts_t               sts,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               freq_error,
    output logic [CNT_W-1:0]   mismatch_count,
    output logic [RATIO_W-1:0] ratio_percent,
    output logic               compare_active
);

    // captured item
    logic [FREQ_W-1:0]  lf_reg;
    logic [FREQ_W-1:0]  rf_reg;
    logic               mute_reg;
    logic               lstill_reg;
    logic               rstill_reg;
    logic               complete_reg;
    logic               ack_reg;

    // divider
    logic [RATIO_W-1:0] num_reg;
    logic [RATIO_W-1:0] num_next;
    logic [FREQ_W-1:0]  div_reg;
    logic [FREQ_W-1:0]  div_next;
    logic [FREQ_W-1:0]  rem_reg;
    logic [FREQ_W-1:0]  rem_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;

    // monitor state
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               err_reg;
    logic               err_next;
    ack_phase_t         ack_phase_reg;
    ack_phase_t         ack_phase_next;

    // output register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               freq_error_reg;
    logic [CNT_W-1:0]   mismatch_count_reg;
    logic [RATIO_W-1:0] ratio_percent_reg;
    logic               compare_active_reg;

    logic [FREQ_W-1:0]  lf_adj;
    logic [FREQ_W-1:0]  rf_adj;
    logic [FREQ_W-1:0]  larger;
    logic [FREQ_W-1:0]  smaller;
    logic               active;
    logic [FREQ_W:0]    rem_shift;
    logic [FREQ_W:0]    rem_diff;
    logic               q_bit;
    logic [CNT_W-1:0]   cnt_inc;

    // zero reads as one
    assign lf_adj  = (lf_reg == '0) ? FREQ_W'(1) : lf_reg;
    assign rf_adj  = (rf_reg == '0) ? FREQ_W'(1) : rf_reg;
    assign larger  = (lf_adj > rf_adj) ? lf_adj : rf_adj;
    assign smaller = (lf_adj > rf_adj) ? rf_adj : lf_adj;
    assign active  = complete_reg & ~mute_reg & ~(lstill_reg & rstill_reg)
                   & ~((lf_adj < cfg.compare_threshold) & (rf_adj < cfg.compare_threshold));

    // restoring division, one quotient bit per step
    assign rem_shift = {rem_reg, num_reg[RATIO_W-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign q_bit     = (rem_shift >= {1'b0, div_reg});

    always_comb
    begin
        num_next  = num_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        if (cmd.prep)
        begin
            // a skipped comparison leaves a zero ratio in place
            num_next  = active ? (RATIO_W'(larger) * RATIO_W'(RATIO_SCALE)) : '0;
            div_next  = smaller;
            rem_next  = '0;
            step_next = STEP_W'(RATIO_W - 1);
        end
        else if (cmd.div_step)
        begin
            num_next  = {num_reg[RATIO_W-2:0], q_bit};
            rem_next  = q_bit ? rem_diff[FREQ_W-1:0] : rem_shift[FREQ_W-1:0];
            step_next = step_reg - STEP_W'(1);
        end
    end

    assign sts.active   = active;
    assign sts.div_last = (step_reg == '0);
    assign sts.out_free = ~out_valid_reg | ~out_stall;

    assign cnt_inc = (cnt_reg != MAX_COUNT) ? (cnt_reg + CNT_W'(1)) : cnt_reg;

    always_comb
    begin
        cnt_next       = cnt_reg;
        err_next       = err_reg;
        ack_phase_next = ack_phase_reg;
        if (cmd.commit)
        begin
            if (!complete_reg)
            begin
                cnt_next = '0;
                err_next = 1'b0;
            end
            else if (!active)
            begin
                cnt_next = '0;
            end
            else if (num_reg > RATIO_W'(cfg.ratio_limit))
            begin
                cnt_next = cnt_inc;
                if (cnt_inc > cfg.persist_limit)
                begin
                    err_next = 1'b1;
                end
            end
            else if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end

            // acknowledge: rise, then fall clears, then a holdoff for one committed item
            case (ack_phase_reg)
                ACK_WAIT_RISE:
                begin
                    if (ack_reg)
                    begin
                        ack_phase_next = ACK_WAIT_FALL;
                    end
                end
                ACK_WAIT_FALL:
                begin
                    if (!ack_reg)
                    begin
                        ack_phase_next = ACK_HOLDOFF;
                        cnt_next       = '0;
                        err_next       = 1'b0;
                    end
                end
                default:
                begin
                    ack_phase_next = ACK_WAIT_RISE;
                end
            endcase
        end
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg & out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            err_reg       <= 1'b0;
            ack_phase_reg <= ACK_WAIT_RISE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            ack_phase_reg <= ack_phase_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        if (cmd.load)
        begin
            lf_reg       <= local_freq;
            rf_reg       <= remote_freq;
            mute_reg     <= muting;
            lstill_reg   <= local_standstill;
            rstill_reg   <= remote_standstill;
            complete_reg <= params_complete;
            ack_reg      <= ack_request;
        end
        if (cmd.commit)
        begin
            freq_error_reg     <= err_next;
            mismatch_count_reg <= cnt_next;
            ratio_percent_reg  <= num_reg;
            compare_active_reg <= active;
        end
    end

    assign out_valid      = out_valid_reg;
    assign freq_error     = freq_error_reg;
    assign mismatch_count = mismatch_count_reg;
    assign ratio_percent  = ratio_percent_reg;
    assign compare_active = compare_active_reg;

endmodule
